// File: hdl/tbp_pkg.sv
`timescale 1ns / 1ps

package tbp_pkg;

    // Default table geometry.
    localparam int GLOBAL_HIST_BITS_DEF = 9;
    localparam int LOCAL_HIST_BITS_DEF  = 10;
    localparam int PC_INDEX_BITS_DEF    = 10;

    // Two-bit saturating counter values.
    localparam logic [1:0] CNT_MIN     = 2'd0;
    localparam logic [1:0] CNT_WEAK_NT = 2'd1;
    localparam logic [1:0] CNT_MAX     = 2'd3;

    // Control sequencer states.
    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_LOOK  = 4'b0100,
        S_UPD   = 4'b1000
    } t_state;

    // Move a two-bit counter one step toward taken or not-taken, saturating.
    function automatic logic [1:0] sat_move(input logic [1:0] c, input logic up);
        logic [1:0] res;
        if (up) begin
            res = (c == CNT_MAX) ? CNT_MAX : c + 2'd1;
        end else begin
            res = (c == CNT_MIN) ? CNT_MIN : c - 2'd1;
        end
        return res;
    endfunction

endpackage

// File: hdl/tbp_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module tbp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // A read at the address being written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/tournament_branch_predictor_core.sv
`timescale 1ns / 1ps

// Channel   Handshake            Payload
// input     i_valid / o_stall    i_mode, i_pc, i_outcome
// output    o_valid / i_stall    o_taken, o_used_local
//
// An item goes through two steps: the local history read, then the local counter read
// that it addresses, which is also the update step.
// The result is registered when the update step completes, which needs a free output.
// After reset a clearing pass over 2^max(PC_INDEX_BITS, LOCAL_HIST_BITS,
// GLOBAL_HIST_BITS) addresses (1024 by default) initializes the tables.
// A stalled output holds the update step, and with it the input.
module tournament_branch_predictor_core
    import tbp_pkg::*;
#(
    parameter int GLOBAL_HIST_BITS = GLOBAL_HIST_BITS_DEF,
    parameter int LOCAL_HIST_BITS  = LOCAL_HIST_BITS_DEF,
    parameter int PC_INDEX_BITS    = PC_INDEX_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_mode,
    input  logic [31:0] i_pc,
    input  logic        i_outcome,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_taken,
    output logic        o_used_local
);

    localparam int MAX_AB   = (PC_INDEX_BITS > LOCAL_HIST_BITS) ? PC_INDEX_BITS
                                                                : LOCAL_HIST_BITS;
    localparam int CLR_BITS = (MAX_AB > GLOBAL_HIST_BITS) ? MAX_AB : GLOBAL_HIST_BITS;

    t_state r_state, n_state;
    logic [CLR_BITS-1:0] r_clr;

    // Item registers.
    logic                       r_train;
    logic                       r_outc;
    logic [PC_INDEX_BITS-1:0]   r_pidx;
    logic [LOCAL_HIST_BITS-1:0] r_lidx;
    logic [1:0]                 r_gc;
    logic [1:0]                 r_ch;
    logic [GLOBAL_HIST_BITS-1:0] r_ghist, n_ghist;

    // Forwarding of a write that lands on the edge the next item is read.
    logic                       r_fwd_lht;
    logic [LOCAL_HIST_BITS-1:0] r_fwd_lht_data;
    logic                       r_fwd_gch;
    logic [3:0]                 r_fwd_gch_data;

    // Result register.
    logic r_out_valid;
    logic r_taken;
    logic r_used_local;

    // Memory ports.
    logic                        lht_we, lcnt_we, gch_we;
    logic [PC_INDEX_BITS-1:0]    lht_waddr;
    logic [LOCAL_HIST_BITS-1:0]  lht_wdata, lht_rdata;
    logic [LOCAL_HIST_BITS-1:0]  lcnt_waddr, lcnt_raddr;
    logic [1:0]                  lcnt_wdata, lcnt_rdata;
    logic [3:0]                  gch_wdata, gch_rdata;

    // Datapath signals.
    logic                        clearing, clr_done;
    logic                        in_acc, out_free, upd_fire, upd_train;
    logic [LOCAL_HIST_BITS-1:0]  look_lidx;
    logic [3:0]                  look_gch;
    logic                        local_pred, global_pred, use_local, pred;
    logic                        lok, gok;
    logic [1:0]                  new_ch, new_gc, new_lc;
    logic [LOCAL_HIST_BITS:0]    lht_shift;
    logic [GLOBAL_HIST_BITS:0]   ghist_shift;

    // Handshake and sequencing.
    assign clearing  = (r_state == S_CLEAR);
    assign clr_done  = &r_clr;
    assign out_free  = !r_out_valid || !i_stall;
    assign upd_fire  = (r_state == S_UPD) && out_free;
    assign upd_train = upd_fire && r_train;
    assign o_stall   = !((r_state == S_IDLE) || upd_fire);
    assign in_acc    = i_valid && !o_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_acc) n_state = S_LOOK;
            end
            S_LOOK: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (out_free) n_state = in_acc ? S_LOOK : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Lookup stage: resolve the local index and the global/chooser pair.
    assign look_lidx  = r_fwd_lht ? r_fwd_lht_data : lht_rdata;
    assign look_gch   = r_fwd_gch ? r_fwd_gch_data : gch_rdata;
    assign lcnt_raddr = (r_state == S_LOOK) ? look_lidx : r_lidx;

    // Prediction and update from the pre-update state.
    assign local_pred  = lcnt_rdata[1];
    assign global_pred = r_gc[1];
    assign use_local   = r_ch[1];
    assign pred        = use_local ? local_pred : global_pred;
    assign lok         = (local_pred == r_outc);
    assign gok         = (global_pred == r_outc);

    always_comb begin
        if (lok && !gok) begin
            new_ch = sat_move(r_ch, 1'b1);
        end else if (gok && !lok) begin
            new_ch = sat_move(r_ch, 1'b0);
        end else begin
            new_ch = r_ch;
        end
    end

    assign new_gc      = sat_move(r_gc, r_outc);
    assign new_lc      = sat_move(lcnt_rdata, r_outc);
    assign lht_shift   = {r_lidx, r_outc};
    assign ghist_shift = {r_ghist, r_outc};
    assign n_ghist     = upd_train ? ghist_shift[GLOBAL_HIST_BITS-1:0] : r_ghist;

    // Write ports: the clearing pass, or a training update.
    assign lht_we     = clearing || upd_train;
    assign lht_waddr  = clearing ? r_clr[PC_INDEX_BITS-1:0] : r_pidx;
    assign lht_wdata  = clearing ? '0 : lht_shift[LOCAL_HIST_BITS-1:0];
    assign lcnt_we    = clearing || upd_train;
    assign lcnt_waddr = clearing ? r_clr[LOCAL_HIST_BITS-1:0] : r_lidx;
    assign lcnt_wdata = clearing ? CNT_WEAK_NT : new_lc;
    assign gch_we     = clearing || upd_train;
    assign gch_wdata  = clearing ? {CNT_WEAK_NT, CNT_WEAK_NT} : {new_ch, new_gc};

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_ghist     <= '0;
            r_out_valid <= 1'b0;
            r_fwd_lht   <= 1'b0;
            r_fwd_gch   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ghist <= n_ghist;
            if (clearing) begin
                r_clr <= r_clr + CLR_BITS'(1);
            end
            if (upd_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (in_acc) begin
                r_fwd_lht <= upd_train && (i_pc[PC_INDEX_BITS-1:0] == r_pidx);
                r_fwd_gch <= upd_train && (n_ghist == r_ghist);
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_train        <= i_mode;
            r_outc         <= i_outcome;
            r_pidx         <= i_pc[PC_INDEX_BITS-1:0];
            r_fwd_lht_data <= lht_shift[LOCAL_HIST_BITS-1:0];
            r_fwd_gch_data <= {new_ch, new_gc};
        end
        if (r_state == S_LOOK) begin
            r_lidx <= look_lidx;
            r_ch   <= look_gch[3:2];
            r_gc   <= look_gch[1:0];
        end
        if (upd_fire) begin
            r_taken      <= pred;
            r_used_local <= use_local;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_taken      = r_taken;
    assign o_used_local = r_used_local;

    // Local history table, indexed by the low pc bits.
    tbp_ram #(
        .WIDTH(LOCAL_HIST_BITS),
        .DEPTH(1 << PC_INDEX_BITS)
    ) u_lht (
        .i_clk  (i_clk),
        .i_we   (lht_we),
        .i_waddr(lht_waddr),
        .i_wdata(lht_wdata),
        .i_raddr(i_pc[PC_INDEX_BITS-1:0]),
        .o_rdata(lht_rdata)
    );

    // Local counters, indexed by the local history.
    tbp_ram #(
        .WIDTH(2),
        .DEPTH(1 << LOCAL_HIST_BITS)
    ) u_lcnt (
        .i_clk  (i_clk),
        .i_we   (lcnt_we),
        .i_waddr(lcnt_waddr),
        .i_wdata(lcnt_wdata),
        .i_raddr(lcnt_raddr),
        .o_rdata(lcnt_rdata)
    );

    // Chooser and global counter pairs, indexed by the global history.
    tbp_ram #(
        .WIDTH(4),
        .DEPTH(1 << GLOBAL_HIST_BITS)
    ) u_gch (
        .i_clk  (i_clk),
        .i_we   (gch_we),
        .i_waddr(clearing ? r_clr[GLOBAL_HIST_BITS-1:0] : r_ghist),
        .i_wdata(gch_wdata),
        .i_raddr(n_ghist),
        .o_rdata(gch_rdata)
    );

`ifndef SYNTHESIS
    // An accepted item always moves on to the lookup cycle.
    a_acc_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == S_LOOK))
        else $error("accepted item did not enter lookup");

    // Outside the clearing pass, tables are written only by a finished training item.
    a_write_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (lcnt_we && (r_state != S_CLEAR)) |-> (upd_fire && r_train))
        else $error("table write outside a training update");

    // A finished update always presents a result.
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        upd_fire |=> o_valid)
        else $error("update finished without a result");

    // Global history changes only on a training update.
    a_ghist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !upd_train |=> $stable(r_ghist))
        else $error("global history changed without training");
`endif

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top
    import tbp_pkg::*;
;

    // Table geometry of the default build.
    localparam int GH_BITS = GLOBAL_HIST_BITS_DEF;
    localparam int LH_BITS = LOCAL_HIST_BITS_DEF;
    localparam int PC_BITS = PC_INDEX_BITS_DEF;

    // Request kinds carried by i_mode.
    localparam logic MODE_PREDICT = 1'b0;
    localparam logic MODE_TRAIN   = 1'b1;

    // A two-bit counter at or above this value votes taken.
    localparam logic [1:0] CNT_TAKEN_MIN = 2'd2;

    // Run shape.
    localparam int RANDOM_PER_PHASE = 200;
    localparam int SITES            = 8;
    localparam int LONG_HOLD        = 80;
    localparam int DRAIN_CYCLES     = 20;
    localparam int WATCHDOG_LIMIT   = 6000;

    // Outcome patterns of the synthetic branch sites.
    typedef enum int {
        PAT_ALWAYS,
        PAT_NEVER,
        PAT_ALTERNATE,
        PAT_LOOP,
        PAT_NOISE
    } t_pattern;

    // One expected result item.
    typedef struct packed {
        logic taken;
        logic used_local;
    } t_guess;

    // Predictor state mirror plus the queue of expected result items.
    class tbp_scoreboard;
        logic [GH_BITS-1:0] ghist;
        logic [LH_BITS-1:0] lhist   [1 << PC_BITS];
        logic [1:0]         lcnt    [1 << LH_BITS];
        logic [1:0]         gcnt    [1 << GH_BITS];
        logic [1:0]         chooser [1 << GH_BITS];
        t_guess             guess_q [$];
        int                 errors;

        function new();
            errors = 0;
            ghist  = '0;
            foreach (lhist[i]) lhist[i] = '0;
            foreach (lcnt[i]) lcnt[i] = CNT_WEAK_NT;
            foreach (gcnt[i]) begin
                gcnt[i]    = CNT_WEAK_NT;
                chooser[i] = CNT_WEAK_NT;
            end
        endfunction

        // Saturating one-step move of a two-bit counter.
        function logic [1:0] nudge(logic [1:0] c, logic up);
            if (up) begin
                return (c == CNT_MAX) ? CNT_MAX : c + 2'd1;
            end
            return (c == CNT_MIN) ? CNT_MIN : c - 2'd1;
        endfunction

        function int pending();
            return guess_q.size();
        endfunction

        // Predict from the current state, queue the guess, then train if asked.
        function void note_input(logic mode, logic [31:0] pc, logic outc);
            logic [PC_BITS-1:0] slot;
            logic [GH_BITS-1:0] gi;
            logic [LH_BITS-1:0] li;
            logic               lp;
            logic               gp;
            t_guess             g;
            slot = pc[PC_BITS-1:0];
            gi   = ghist;
            li   = lhist[slot];
            lp   = (lcnt[li] >= CNT_TAKEN_MIN);
            gp   = (gcnt[gi] >= CNT_TAKEN_MIN);
            g.used_local = (chooser[gi] >= CNT_TAKEN_MIN);
            g.taken      = g.used_local ? lp : gp;
            guess_q.push_back(g);
            if (mode == MODE_TRAIN) begin
                // The chooser only moves when exactly one side was right.
                if (lp == outc && gp != outc) begin
                    chooser[gi] = nudge(chooser[gi], 1'b1);
                end else if (gp == outc && lp != outc) begin
                    chooser[gi] = nudge(chooser[gi], 1'b0);
                end
                gcnt[gi]    = nudge(gcnt[gi], outc);
                lcnt[li]    = nudge(lcnt[li], outc);
                lhist[slot] = {li[LH_BITS-2:0], outc};
                ghist       = {gi[GH_BITS-2:0], outc};
            end
        endfunction

        // Compare one result item against the oldest guess.
        function void check_result(logic taken, logic used_local);
            t_guess g;
            if (guess_q.size() == 0) begin
                $error("unexpected result item: taken=%0b used_local=%0b", taken, used_local);
                errors++;
                return;
            end
            g = guess_q.pop_front();
            if (taken !== g.taken) begin
                $error("taken: expected %0b, actual %0b", g.taken, taken);
                errors++;
            end
            if (used_local !== g.used_local) begin
                $error("used_local: expected %0b, actual %0b", g.used_local, used_local);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_valid    = 1'b0;
    logic        o_stall;
    logic        i_mode     = MODE_PREDICT;
    logic [31:0] i_pc       = '0;
    logic        i_outcome  = 1'b0;
    logic        o_valid;
    logic        i_stall    = 1'b0;
    logic        o_taken;
    logic        o_used_local;

    tbp_scoreboard sb = new();

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    logic hold_arm    = 1'b0;
    logic hold_used   = 1'b0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    logic [PC_BITS-1:0] site_idx    [SITES];
    t_pattern           site_pat    [SITES];
    int                 site_period [SITES];
    int                 site_trip   [SITES];

    tournament_branch_predictor_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_mode       (i_mode),
        .i_pc         (i_pc),
        .i_outcome    (i_outcome),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_taken      (o_taken),
        .o_used_local (o_used_local)
    );

    // 4 ns clock.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Receiver back-pressure: one long hold-off when armed, random stalls otherwise.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left != 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_arm && !hold_used) begin
            i_stall   <= 1'b1;
            hold_left <= LONG_HOLD - 1;
            hold_used <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_result(o_taken, o_used_local);
        end
    end

    // Watchdog on cycles where neither channel moves an item.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one item after a random gap and wait until it is taken.
    task automatic send_item(input logic mode, input logic [31:0] pc, input logic outc);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_mode    <= mode;
        i_pc      <= pc;
        i_outcome <= outc;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_input(mode, pc, outc);
    endtask

    // Stop offering until every expected result item is back.
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Pick a fresh set of branch sites, each with its own outcome pattern.
    task automatic pick_sites();
        for (int k = 0; k < SITES; k++) begin
            site_idx[k]    = PC_BITS'($urandom_range((1 << PC_BITS) - 1));
            site_pat[k]    = t_pattern'(k % 5);
            site_period[k] = $urandom_range(6, 2);
            site_trip[k]   = 0;
        end
    endtask

    // Mostly trained branch sites with patterned outcomes, some plain noise.
    task automatic run_random_item();
        int          k;
        logic        outc;
        logic [31:0] pc;
        if ($urandom_range(99) < 15) begin
            send_item(logic'($urandom_range(1)), $urandom(), logic'($urandom_range(1)));
        end else begin
            k  = $urandom_range(SITES - 1);
            pc = $urandom();
            pc[PC_BITS-1:0] = site_idx[k];
            case (site_pat[k])
                PAT_ALWAYS:    outc = 1'b1;
                PAT_NEVER:     outc = 1'b0;
                PAT_ALTERNATE: outc = site_trip[k][0];
                PAT_LOOP:      outc = (site_trip[k] % site_period[k]) != site_period[k] - 1;
                default:       outc = logic'($urandom_range(1));
            endcase
            if ($urandom_range(9) == 0) begin
                send_item(MODE_PREDICT, pc, logic'($urandom_range(1)));
            end else begin
                send_item(MODE_TRAIN, pc, outc);
                site_trip[k]++;
            end
        end
    endtask

    initial begin
        // Hold synchronous reset first; the block then clears its tables.
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Predict-only requests at the address extremes; outcome must be ignored.
        send_item(MODE_PREDICT, 32'h0000_0000, 1'b1);
        send_item(MODE_PREDICT, 32'hFFFF_FFFF, 1'b0);

        // Saturate toward taken; high address bits alias to the same entry.
        send_item(MODE_TRAIN, 32'h0000_0000, 1'b1);
        send_item(MODE_TRAIN, 32'h0000_0000, 1'b1);
        send_item(MODE_TRAIN, 32'hFFFF_FC00, 1'b1);
        send_item(MODE_TRAIN, 32'h0000_0000, 1'b1);
        send_item(MODE_TRAIN, 32'h8000_0000, 1'b1);

        // Saturate toward not-taken at the top index.
        send_item(MODE_TRAIN, 32'h0000_03FF, 1'b0);
        send_item(MODE_TRAIN, 32'h0000_03FF, 1'b0);
        send_item(MODE_TRAIN, 32'hFFFF_FFFF, 1'b0);
        send_item(MODE_TRAIN, 32'h0000_03FF, 1'b0);

        // Alternating branches make the two predictors disagree.
        send_item(MODE_TRAIN, 32'h0000_0155, 1'b1);
        send_item(MODE_TRAIN, 32'hAAAA_A2AA, 1'b0);
        send_item(MODE_TRAIN, 32'h0000_0155, 1'b1);
        send_item(MODE_TRAIN, 32'hAAAA_A2AA, 1'b0);
        send_item(MODE_TRAIN, 32'h0000_0155, 1'b0);
        send_item(MODE_TRAIN, 32'hAAAA_A2AA, 1'b1);
        send_item(MODE_TRAIN, 32'h0000_0155, 1'b1);
        send_item(MODE_TRAIN, 32'hAAAA_A2AA, 1'b0);

        // Predictions after training, state must stay put.
        send_item(MODE_PREDICT, 32'h0000_0155, 1'b1);
        send_item(MODE_PREDICT, 32'h0000_0155, 1'b0);

        // Random phases: sender-light, receiver-light, then no random idling but one long receiver hold-off.
        for (int ph = 0; ph < 3; ph++) begin
            wait_drained();
            pick_sites();
            if (ph == 0) begin
                send_idle_pct = 23;
                recv_idle_pct <= 74;
            end else if (ph == 1) begin
                send_idle_pct = 74;
                recv_idle_pct <= 23;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
                hold_arm      <= 1'b1;
            end
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                run_random_item();
            end
        end

        // Let the last results come back, then let the block idle before the verdict.
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
